/* hdl/dlpg_pkg.sv */
// ----------------------------------------------------------------------------
// DDA line pixel generator package
// Shared widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dlpg_pkg;

   localparam int COORD_W  = 16;
   localparam int SPAN_W   = 16;
   localparam int PTS_W    = 17;
   localparam int DIM_W    = 13;
   localparam int COLOUR_W = 32;
   localparam int ADDR_W   = 24;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd800;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd600;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_ADDR  = 5'b10000
   } state_type;

endpackage

/* hdl/dda_line_pixel_generator_core.sv */
// ----------------------------------------------------------------------------
// DDA line pixel generator core
// Rasterizes one line segment into frame-buffer writes, one per step request.
// ----------------------------------------------------------------------------
// A start request (action 0) loads both endpoints and the colour; the block
// then runs one shared restoring divider twice, X increment then Y increment,
// FRAC_BITS+1 quotient bits per pass after a load state; no further request is
// taken until both passes are done (a zero-length line skips the divider).
// A step request (action 1) on an active line takes three steps: accept, round
// and bounds check, then the y*width+x multiply-add into the output register,
// which waits out a stalled result; a step while no line is active is
// absorbed. The output register lets a new request in while a result waits.
// Increments are signed fixed point with FRAC_BITS fraction bits, rounded to
// nearest with ties away from zero; pixel positions round the same way.
module dda_line_pixel_generator_core #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_DIM   = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic signed [dlpg_pkg::COORD_W-1:0]  req_x_start,
   input  logic signed [dlpg_pkg::COORD_W-1:0]  req_y_start,
   input  logic signed [dlpg_pkg::COORD_W-1:0]  req_x_end,
   input  logic signed [dlpg_pkg::COORD_W-1:0]  req_y_end,
   input  logic        [dlpg_pkg::COLOUR_W-1:0] req_line_colour,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [dlpg_pkg::ADDR_W-1:0]   rsp_pixel_address,
   output logic        [dlpg_pkg::COLOUR_W-1:0] rsp_pixel_colour,
   output logic                                 rsp_write_enable,
   output logic                                 rsp_last_pixel,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [dlpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [dlpg_pkg::DIM_W-1:0]    csr_wdata
);
   import dlpg_pkg::*;

   localparam int ACC_W   = 18 + FRAC_BITS;
   localparam int INC_W   = 2 + FRAC_BITS;
   localparam int QUO_W   = FRAC_BITS + 1;
   localparam int NUM_W   = SPAN_W + FRAC_BITS + 1;
   localparam int RND_W   = ACC_W + 1;
   localparam int PIX_W   = RND_W - FRAC_BITS;
   localparam int EXT_W   = ACC_W - COORD_W - FRAC_BITS;
   localparam int CNT_W   = $clog2(QUO_W);
   localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
   localparam logic [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

   state_type               state_ff, state_in;
   logic                    axis_ff, axis_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SPAN_W-1:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]        nq_ff, nq_in;
   logic [SPAN_W-1:0]       span_ff, span_in;
   logic [SPAN_W-1:0]       mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                    neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [INC_W-1:0]        inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [ACC_W-1:0]        acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [PTS_W-1:0]        pts_ff, pts_in;
   logic [COLOUR_W-1:0]     colour_ff, colour_in;
   logic                    active_ff, active_in;
   logic [DIM_W-1:0]        xpix_ff, xpix_in, ypix_ff, ypix_in;
   logic                    inside_ff, inside_in;
   logic                    last_ff, last_in;
   logic [DIM_W-1:0]        width_ff, width_in, height_ff, height_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [COLOUR_W-1:0]     rsp_colour_ff, rsp_colour_in;
   logic                    rsp_we_ff, rsp_we_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_take;
   logic [COORD_W:0]        dx, dy, ax, ay;
   logic [SPAN_W-1:0]       span_new;
   logic [SPAN_W-1:0]       mag_sel;
   logic [NUM_W-1:0]        num;
   logic [SPAN_W:0]         shifted;
   logic [SPAN_W+1:0]       diff;
   logic                    qbit;
   logic [QUO_W-1:0]        quo;
   logic [INC_W-1:0]        inc_mag, inc_new;
   logic [RND_W-1:0]        sum_x, sum_y;
   logic [PIX_W-1:0]        rnd_x, rnd_y;
   logic [DIM_W-1:0]        csr_val;
   logic [2*DIM_W-1:0]      prod;
   logic [2*DIM_W:0]        lin_addr;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_colour  = rsp_colour_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   // line set-up: spans of both axes
   assign dx = {req_x_end[COORD_W-1], req_x_end} - {req_x_start[COORD_W-1], req_x_start};
   assign dy = {req_y_end[COORD_W-1], req_y_end} - {req_y_start[COORD_W-1], req_y_start};
   assign ax = dx[COORD_W] ? -dx : dx;
   assign ay = dy[COORD_W] ? -dy : dy;
   assign span_new = (ax >= ay) ? ax[SPAN_W-1:0] : ay[SPAN_W-1:0];

   // shared divider: numerator is mag*2^F + span/2
   assign mag_sel = axis_ff ? mag_y_ff : mag_x_ff;
   assign num     = NUM_W'({mag_sel, {FRAC_BITS{1'b0}}}) + NUM_W'(span_ff[SPAN_W-1:1]);
   assign shifted = {rem_ff, nq_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, span_ff};
   assign qbit    = !diff[SPAN_W+1];
   assign quo     = {nq_ff[QUO_W-2:0], qbit};
   assign inc_mag = {1'b0, quo};
   assign inc_new = (axis_ff ? neg_y_ff : neg_x_ff) ? -inc_mag : inc_mag;

   // round half away from zero: (a + half - [a<0]) >>> F
   assign sum_x = {acc_x_ff[ACC_W-1], acc_x_ff} + HALF - RND_W'(acc_x_ff[ACC_W-1]);
   assign sum_y = {acc_y_ff[ACC_W-1], acc_y_ff} + HALF - RND_W'(acc_y_ff[ACC_W-1]);
   assign rnd_x = sum_x[RND_W-1:FRAC_BITS];
   assign rnd_y = sum_y[RND_W-1:FRAC_BITS];

   assign prod     = ypix_ff * width_ff;
   assign lin_addr = {1'b0, prod} + (2*DIM_W+1)'(xpix_ff);

   assign csr_val = (32'(csr_wdata) > DIM_CAP) ? DIM_W'(DIM_CAP) : csr_wdata;

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      nq_in         = nq_ff;
      span_in       = span_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      inc_x_in      = inc_x_ff;
      inc_y_in      = inc_y_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      pts_in        = pts_ff;
      colour_in     = colour_ff;
      active_in     = active_ff;
      xpix_in       = xpix_ff;
      ypix_in       = ypix_ff;
      inside_in     = inside_ff;
      last_in       = last_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_we_in     = rsp_we_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_val;
            REG_FRAME_HEIGHT: height_in = csr_val;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_START) begin
                  span_in   = span_new;
                  mag_x_in  = ax[SPAN_W-1:0];
                  mag_y_in  = ay[SPAN_W-1:0];
                  neg_x_in  = dx[COORD_W];
                  neg_y_in  = dy[COORD_W];
                  acc_x_in  = {{EXT_W{req_x_start[COORD_W-1]}}, req_x_start,
                               {FRAC_BITS{1'b0}}};
                  acc_y_in  = {{EXT_W{req_y_start[COORD_W-1]}}, req_y_start,
                               {FRAC_BITS{1'b0}}};
                  pts_in    = PTS_W'(span_new) + PTS_W'(1);
                  colour_in = req_line_colour;
                  active_in = 1'b1;
                  axis_in   = 1'b0;
                  inc_x_in  = '0;
                  inc_y_in  = '0;
                  if (span_new != '0) begin
                     state_in = ST_LOAD;
                  end
               end else if (active_ff) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LOAD: begin
            rem_in   = num[NUM_W-1 -: SPAN_W];
            nq_in    = num[QUO_W-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? diff[SPAN_W-1:0] : shifted[SPAN_W-1:0];
            nq_in  = quo;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_BITS)) begin
               if (axis_ff) begin
                  inc_y_in = inc_new;
                  state_in = ST_IDLE;
               end else begin
                  inc_x_in = inc_new;
                  axis_in  = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ROUND: begin
            xpix_in   = rnd_x[DIM_W-1:0];
            ypix_in   = rnd_y[DIM_W-1:0];
            inside_in = !rnd_x[PIX_W-1] && (rnd_x < PIX_W'(width_ff)) &&
                        !rnd_y[PIX_W-1] && (rnd_y < PIX_W'(height_ff));
            last_in   = (pts_ff == PTS_W'(1));
            pts_in    = pts_ff - PTS_W'(1);
            if (pts_ff == PTS_W'(1)) begin
               active_in = 1'b0;
            end
            acc_x_in  = acc_x_ff + {{(ACC_W-INC_W){inc_x_ff[INC_W-1]}}, inc_x_ff};
            acc_y_in  = acc_y_ff + {{(ACC_W-INC_W){inc_y_ff[INC_W-1]}}, inc_y_ff};
            state_in  = ST_ADDR;
         end
         ST_ADDR: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = inside_ff ? lin_addr[ADDR_W-1:0] : '0;
               rsp_colour_in = colour_ff;
               rsp_we_in     = inside_ff;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff       <= axis_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      nq_ff         <= nq_in;
      span_ff       <= span_in;
      mag_x_ff      <= mag_x_in;
      mag_y_ff      <= mag_y_in;
      neg_x_ff      <= neg_x_in;
      neg_y_ff      <= neg_y_in;
      inc_x_ff      <= inc_x_in;
      inc_y_ff      <= inc_y_in;
      acc_x_ff      <= acc_x_in;
      acc_y_ff      <= acc_y_in;
      pts_ff        <= pts_in;
      colour_ff     <= colour_in;
      xpix_ff       <= xpix_in;
      ypix_ff       <= ypix_in;
      inside_ff     <= inside_in;
      last_ff       <= last_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_we_ff     <= rsp_we_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_div_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(FRAC_BITS)))
      else $error("divider ran past its last quotient bit");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && pts_ff == PTS_W'(1)) |=> !active_ff)
      else $error("line still active after its last point");

   a_step_needs_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> active_ff)
      else $error("pixel computed without an active line");

   a_masked_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_we_ff) |-> (rsp_addr_ff == '0))
      else $error("address nonzero on a point outside the frame");

   a_result_from_addr: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ADDR))
      else $error("result appeared outside the address stage");

endmodule
